// ===== rtl/core/isotp_pkg.sv =====
package isotp_pkg;

   // Transmit store geometry: eight byte lanes so that any seven consecutive
   // bytes come out of one read of every lane.
   localparam int TX_BUF_BYTES = 4096;
   localparam int TX_AW        = $clog2(TX_BUF_BYTES);
   localparam int LANES        = 8;
   localparam int LANE_AW      = $clog2(LANES);
   localparam int ROWS         = TX_BUF_BYTES / LANES;
   localparam int ROW_AW       = $clog2(ROWS);

   // Item operations.
   localparam logic [1:0] OP_RX_FRAME = 2'd0;
   localparam logic [1:0] OP_LOAD     = 2'd1;
   localparam logic [1:0] OP_START    = 2'd2;
   localparam logic [1:0] OP_SLOT     = 2'd3;

   // Protocol control nibbles.
   localparam logic [3:0] PCI_SINGLE = 4'h0;
   localparam logic [3:0] PCI_FIRST  = 4'h1;
   localparam logic [3:0] PCI_CONSEC = 4'h2;
   localparam logic [3:0] PCI_FLOW   = 4'h3;

   localparam logic [3:0] FS_WAIT     = 4'h1;
   localparam logic [3:0] FS_OVERFLOW = 4'h2;

   localparam logic [7:0] FC_CTS_BYTE  = 8'h30;
   localparam logic [7:0] FC_BS_BYTE   = 8'h00;
   localparam logic [7:0] FC_GAP_BYTE  = 8'hF9;
   localparam logic [7:0] STMIN_MS_MAX = 8'd127;
   localparam logic [7:0] STMIN_US_LO  = 8'hF3;
   localparam logic [7:0] STMIN_US_HI  = 8'hF9;

   // Configuration register indexes.
   localparam logic [1:0] CSR_TX_IDENTIFIER = 2'd0;
   localparam logic [1:0] CSR_TX_EXTENDED   = 2'd1;
   localparam logic [1:0] CSR_PAD_ENABLE    = 2'd2;
   localparam logic [1:0] CSR_PAD_VALUE     = 2'd3;

   typedef struct packed {
      logic [28:0] tx_identifier;
      logic        tx_extended;
      logic        pad_enable;
      logic [7:0]  pad_value;
   } cfg_type;

   // One accepted item that causes results, as handed to the output stage.
   typedef struct packed {
      logic        is_rx;
      logic        two;
      logic [28:0] rx_id;
      logic        rx_ext;
      logic [3:0]  cnt;
      logic [63:0] rx_data;
      logic [11:0] offset;
      logic [11:0] mlen;
      logic        done;
      logic        hdr_two;
      logic [7:0]  hdr0;
      logic [7:0]  hdr1;
      logic [LANE_AW-1:0] rot;
      logic [7:0]  gms;
      logic [3:0]  gus;
   } desc_type;

   typedef struct packed {
      logic             wr_en;
      logic [TX_AW-1:0] wr_addr;
      logic [7:0]       wr_data;
      logic             rd_en;
      logic [TX_AW-1:0] rd_addr;
   } store_ctl_type;

endpackage

// ===== rtl/core/isotp_ifs.sv =====
interface isotp_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  op;
   logic [28:0] rx_identifier;
   logic        rx_is_extended;
   logic [3:0]  rx_length_code;
   logic [63:0] rx_bytes;
   logic [7:0]  load_byte;
   logic [11:0] send_length;
   modport source (output valid, op, rx_identifier, rx_is_extended, rx_length_code,
                   rx_bytes, load_byte, send_length, input ready);
   modport sink (input valid, op, rx_identifier, rx_is_extended, rx_length_code,
                 rx_bytes, load_byte, send_length, output ready);
endinterface

interface isotp_rsp_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic        last;
   logic [28:0] frame_identifier;
   logic        frame_extended;
   logic [3:0]  length_code;
   logic [63:0] data_bytes;
   logic [11:0] chunk_offset;
   logic [11:0] message_length;
   logic        message_done;
   logic [7:0]  gap_ms;
   logic [3:0]  gap_hundred_us;
   modport source (output valid, kind, last, frame_identifier, frame_extended,
                   length_code, data_bytes, chunk_offset, message_length,
                   message_done, gap_ms, gap_hundred_us, input ready);
   modport sink (input valid, kind, last, frame_identifier, frame_extended,
                 length_code, data_bytes, chunk_offset, message_length,
                 message_done, gap_ms, gap_hundred_us, output ready);
endinterface

interface isotp_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [28:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/core/isotp_segment_reassemble.sv =====
// An accepted item is registered in the output stage, its result then in the
// output registers. Throughput: one item per cycle unless the output stalls;
// a first frame yields two results and holds the output stage for both.
// Reset clears all control and protocol state and restores the register
// defaults at once; the transmit store contents are not cleared.
module isotp_segment_reassemble (
   input  logic        clock,
   input  logic        reset,
   isotp_req_if.sink   req_chan,
   isotp_rsp_if.source rsp_chan,
   isotp_csr_if.sink   csr_chan
);

   isotp_pkg::cfg_type       cfg_ff;
   isotp_pkg::desc_type      desc;
   isotp_pkg::store_ctl_type store_ctl;
   logic [7:0] lane_q [isotp_pkg::LANES];
   logic       can_take, accept, load;

   assign req_chan.ready = can_take;
   assign accept = req_chan.valid && can_take;
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.tx_identifier <= 29'd2016;
         cfg_ff.tx_extended   <= 1'b0;
         cfg_ff.pad_enable    <= 1'b1;
         cfg_ff.pad_value     <= 8'd85;
      end else if (csr_chan.valid) begin
         case (csr_chan.index)
            isotp_pkg::CSR_TX_IDENTIFIER: cfg_ff.tx_identifier <= csr_chan.data;
            isotp_pkg::CSR_TX_EXTENDED:   cfg_ff.tx_extended   <= csr_chan.data[0];
            isotp_pkg::CSR_PAD_ENABLE:    cfg_ff.pad_enable    <= csr_chan.data[0];
            isotp_pkg::CSR_PAD_VALUE:     cfg_ff.pad_value     <= csr_chan.data[7:0];
            default: begin
            end
         endcase
      end
   end

   isotp_seg_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .op             (req_chan.op),
      .rx_identifier  (req_chan.rx_identifier),
      .rx_is_extended (req_chan.rx_is_extended),
      .rx_length_code (req_chan.rx_length_code),
      .rx_bytes       (req_chan.rx_bytes),
      .load_byte      (req_chan.load_byte),
      .send_length    (req_chan.send_length),
      .load           (load),
      .desc           (desc),
      .store_ctl      (store_ctl)
   );

   isotp_seg_store u_store (
      .clock  (clock),
      .ctl    (store_ctl),
      .lane_q (lane_q)
   );

   isotp_seg_fmt u_fmt (
      .clock    (clock),
      .reset    (reset),
      .load     (load),
      .desc_in  (desc),
      .lane_q   (lane_q),
      .cfg      (cfg_ff),
      .can_take (can_take),
      .rsp_chan (rsp_chan)
   );

endmodule

// ===== rtl/core/isotp_seg_store.sv =====
module isotp_seg_store (
   input  logic                    clock,
   input  isotp_pkg::store_ctl_type ctl,
   output logic [7:0]              lane_q [isotp_pkg::LANES]
);

   logic [isotp_pkg::ROW_AW-1:0]  base_row;
   logic [isotp_pkg::LANE_AW-1:0] base_lane;
   logic [isotp_pkg::ROW_AW-1:0]  wr_row;
   logic [isotp_pkg::LANE_AW-1:0] wr_lane;

   assign base_row  = ctl.rd_addr[isotp_pkg::TX_AW-1:isotp_pkg::LANE_AW];
   assign base_lane = ctl.rd_addr[isotp_pkg::LANE_AW-1:0];
   assign wr_row    = ctl.wr_addr[isotp_pkg::TX_AW-1:isotp_pkg::LANE_AW];
   assign wr_lane   = ctl.wr_addr[isotp_pkg::LANE_AW-1:0];

   for (genvar g = 0; g < isotp_pkg::LANES; g++) begin : g_lane
      logic [7:0] mem [isotp_pkg::ROWS];
      logic [isotp_pkg::ROW_AW-1:0] rd_row;

      // Lanes below the start lane hold bytes of the following row.
      assign rd_row = (isotp_pkg::LANE_AW'(g) >= base_lane) ? base_row :
                      base_row + isotp_pkg::ROW_AW'(1);

      always_ff @(posedge clock) begin
         if (ctl.wr_en && wr_lane == isotp_pkg::LANE_AW'(g)) begin
            mem[wr_row] <= ctl.wr_data;
         end
         if (ctl.rd_en) begin
            lane_q[g] <= mem[rd_row];
         end
      end
   end

endmodule

// ===== rtl/core/isotp_seg_ctrl.sv =====
module isotp_seg_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     accept,
   input  logic [1:0]               op,
   input  logic [28:0]              rx_identifier,
   input  logic                     rx_is_extended,
   input  logic [3:0]               rx_length_code,
   input  logic [63:0]              rx_bytes,
   input  logic [7:0]               load_byte,
   input  logic [11:0]              send_length,
   output logic                     load,
   output isotp_pkg::desc_type      desc,
   output isotp_pkg::store_ctl_type store_ctl
);

   logic [11:0] rx_expected_ff, rx_expected_in;
   logic [11:0] rx_received_ff, rx_received_in;
   logic        rx_busy_ff, rx_busy_in;
   logic [isotp_pkg::TX_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [11:0] rd_ptr_ff, rd_ptr_in;
   logic [11:0] tx_left_ff, tx_left_in;
   logic [7:0]  tx_seq_ff, tx_seq_in;
   logic [3:0]  cf_sn_ff, cf_sn_in;
   logic        tx_pending_ff, tx_pending_in;
   logic        burst_ff, burst_in;
   logic [7:0]  block_limit_ff, block_limit_in;
   logic [7:0]  sep_ms_ff, sep_ms_in;
   logic [3:0]  sep_us_ff, sep_us_in;

   logic [3:0]  dlc;
   logic [7:0]  b0, b1, b2;
   logic [3:0]  cnt;
   logic [1:0]  first;
   logic [11:0] exp_len, remaining;
   logic        has_res;
   logic        pend_tmp;

   assign b0 = rx_bytes[7:0];
   assign b1 = rx_bytes[15:8];
   assign b2 = rx_bytes[23:16];
   assign dlc = (rx_length_code > 4'd8) ? 4'd8 : rx_length_code;
   assign exp_len = {b0[3:0], b1};
   assign remaining = rx_expected_ff - rx_received_ff;

   always_comb begin
      rx_expected_in = rx_expected_ff;
      rx_received_in = rx_received_ff;
      rx_busy_in     = rx_busy_ff;
      wr_ptr_in      = wr_ptr_ff;
      rd_ptr_in      = rd_ptr_ff;
      tx_left_in     = tx_left_ff;
      tx_seq_in      = tx_seq_ff;
      cf_sn_in       = cf_sn_ff;
      tx_pending_in  = tx_pending_ff;
      burst_in       = burst_ff;
      block_limit_in = block_limit_ff;
      sep_ms_in      = sep_ms_ff;
      sep_us_in      = sep_us_ff;
      pend_tmp       = tx_pending_ff;
      has_res        = 1'b0;
      cnt            = 4'd0;
      first          = 2'd1;
      store_ctl      = '0;
      store_ctl.wr_addr = wr_ptr_ff;
      store_ctl.wr_data = load_byte;
      desc           = '0;
      desc.rx_id     = rx_identifier;
      desc.rx_ext    = rx_is_extended;
      desc.gms       = sep_ms_ff;
      desc.gus       = sep_us_ff;

      case (op)
         isotp_pkg::OP_RX_FRAME: begin
            desc.is_rx = 1'b1;
            case (b0[7:4])
               isotp_pkg::PCI_SINGLE: begin
                  cnt = (b0[3:0] > 4'd7) ? 4'd7 : b0[3:0];
                  has_res = 1'b1;
                  desc.mlen = {8'd0, cnt};
                  desc.done = 1'b1;
               end
               isotp_pkg::PCI_FIRST: begin
                  cnt = (dlc >= 4'd2) ? dlc - 4'd2 : 4'd0;
                  if ({8'd0, cnt} > exp_len) begin
                     cnt = exp_len[3:0];
                  end
                  first = 2'd2;
                  has_res = 1'b1;
                  desc.two = 1'b1;
                  desc.mlen = exp_len;
                  desc.done = ({8'd0, cnt} == exp_len);
                  rx_expected_in = exp_len;
                  rx_received_in = desc.done ? 12'd0 : {8'd0, cnt};
                  rx_busy_in = !desc.done;
               end
               isotp_pkg::PCI_CONSEC: begin
                  if (rx_busy_ff) begin
                     has_res = 1'b1;
                     desc.offset = rx_received_ff;
                     desc.mlen = rx_expected_ff;
                     if (remaining > 12'd7) begin
                        cnt = (dlc >= 4'd1) ? dlc - 4'd1 : 4'd0;
                        rx_received_in = rx_received_ff + {8'd0, cnt};
                     end else begin
                        cnt = remaining[3:0];
                        desc.done = 1'b1;
                        rx_received_in = 12'd0;
                        rx_busy_in = 1'b0;
                     end
                  end
               end
               isotp_pkg::PCI_FLOW: begin
                  if (b0[3:0] != isotp_pkg::FS_WAIT) begin
                     if (b0[3:0] == isotp_pkg::FS_OVERFLOW) begin
                        pend_tmp = 1'b0;
                     end
                     if (b2 >= 8'd1 && b2 <= isotp_pkg::STMIN_MS_MAX) begin
                        sep_ms_in = b2 + 8'd2;
                     end else if (b2 >= isotp_pkg::STMIN_US_LO &&
                                  b2 <= isotp_pkg::STMIN_US_HI) begin
                        sep_us_in = b2[3:0];
                        sep_ms_in = 8'd0;
                     end else begin
                        sep_ms_in = 8'd0;
                        sep_us_in = 4'd0;
                     end
                     block_limit_in = b1;
                     tx_seq_in = 8'd1;
                     tx_pending_in = pend_tmp;
                     burst_in = pend_tmp && (tx_left_ff != 12'd0);
                  end
               end
               default: begin
               end
            endcase
            for (int i = 0; i < 8; i++) begin
               if (i < int'(cnt) && i + int'(first) < 8) begin
                  desc.rx_data[8*i +: 8] = rx_bytes[8*(i + int'(first)) +: 8];
               end
            end
            desc.cnt = cnt;
         end
         isotp_pkg::OP_LOAD: begin
            store_ctl.wr_en = 1'b1;
            wr_ptr_in = wr_ptr_ff + isotp_pkg::TX_AW'(1);
         end
         isotp_pkg::OP_START: begin
            has_res = 1'b1;
            wr_ptr_in = '0;
            store_ctl.rd_en = 1'b1;
            if (send_length <= 12'd7) begin
               desc.hdr0 = send_length[7:0];
               desc.cnt = send_length[3:0];
               tx_pending_in = 1'b0;
               burst_in = 1'b0;
               tx_left_in = 12'd0;
            end else begin
               desc.hdr_two = 1'b1;
               desc.hdr0 = {isotp_pkg::PCI_FIRST, send_length[11:8]};
               desc.hdr1 = send_length[7:0];
               desc.cnt = 4'd6;
               rd_ptr_in = 12'd6;
               tx_left_in = send_length - 12'd6;
               tx_pending_in = 1'b1;
               burst_in = 1'b0;
               tx_seq_in = 8'd1;
               cf_sn_in = 4'd1;
            end
         end
         isotp_pkg::OP_SLOT: begin
            if (tx_pending_ff && burst_ff && tx_left_ff != 12'd0) begin
               has_res = 1'b1;
               cnt = (tx_left_ff > 12'd7) ? 4'd7 : tx_left_ff[3:0];
               desc.cnt = cnt;
               desc.hdr0 = {isotp_pkg::PCI_CONSEC, cf_sn_ff};
               desc.rot = rd_ptr_ff[isotp_pkg::LANE_AW-1:0];
               store_ctl.rd_en = 1'b1;
               store_ctl.rd_addr = rd_ptr_ff[isotp_pkg::TX_AW-1:0];
               rd_ptr_in = rd_ptr_ff + {8'd0, cnt};
               tx_left_in = tx_left_ff - {8'd0, cnt};
               cf_sn_in = cf_sn_ff + 4'd1;
               if (block_limit_ff != 8'd0 && tx_seq_ff == block_limit_ff) begin
                  burst_in = 1'b0;
               end else begin
                  tx_seq_in = tx_seq_ff + 8'd1;
               end
               if (tx_left_in == 12'd0) begin
                  tx_pending_in = 1'b0;
                  burst_in = 1'b0;
               end
            end
         end
         default: begin
         end
      endcase

      store_ctl.wr_en = store_ctl.wr_en && accept;
      store_ctl.rd_en = store_ctl.rd_en && accept;
   end

   assign load = accept && has_res;

   always_ff @(posedge clock) begin
      if (reset) begin
         rx_expected_ff <= '0;
         rx_received_ff <= '0;
         rx_busy_ff     <= 1'b0;
         wr_ptr_ff      <= '0;
         rd_ptr_ff      <= '0;
         tx_left_ff     <= '0;
         tx_seq_ff      <= 8'd1;
         cf_sn_ff       <= 4'd1;
         tx_pending_ff  <= 1'b0;
         burst_ff       <= 1'b0;
         block_limit_ff <= '0;
         sep_ms_ff      <= '0;
         sep_us_ff      <= '0;
      end else if (accept) begin
         rx_expected_ff <= rx_expected_in;
         rx_received_ff <= rx_received_in;
         rx_busy_ff     <= rx_busy_in;
         wr_ptr_ff      <= wr_ptr_in;
         rd_ptr_ff      <= rd_ptr_in;
         tx_left_ff     <= tx_left_in;
         tx_seq_ff      <= tx_seq_in;
         cf_sn_ff       <= cf_sn_in;
         tx_pending_ff  <= tx_pending_in;
         burst_ff       <= burst_in;
         block_limit_ff <= block_limit_in;
         sep_ms_ff      <= sep_ms_in;
         sep_us_ff      <= sep_us_in;
      end
   end

endmodule

// ===== rtl/core/isotp_seg_fmt.sv =====
module isotp_seg_fmt (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  isotp_pkg::desc_type  desc_in,
   input  logic [7:0]           lane_q [isotp_pkg::LANES],
   input  isotp_pkg::cfg_type   cfg,
   output logic                 can_take,
   isotp_rsp_if.source          rsp_chan
);

   isotp_pkg::desc_type desc_ff;
   logic        held_ff;
   logic        phase_ff;
   logic        rsp_valid_ff;
   logic        out_free, emit, last_now;

   logic        kind_ff, last_ff, ext_ff, done_ff;
   logic [28:0] id_ff;
   logic [3:0]  len_ff, gus_ff;
   logic [63:0] data_ff;
   logic [11:0] off_ff, mlen_ff;
   logic [7:0]  gms_ff;

   logic [7:0]  b [8];
   logic [3:0]  used, tx_len, hdr_n;
   logic [63:0] tx_data;
   logic [isotp_pkg::LANE_AW-1:0] lane_sel;

   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign emit     = held_ff && out_free;
   assign last_now = !desc_ff.two || phase_ff;
   assign can_take = !held_ff || (emit && last_now);

   // Build the transmit frame: header bytes, then store bytes or the
   // flow-control frame, then padding.
   always_comb begin
      hdr_n = desc_ff.hdr_two ? 4'd2 : 4'd1;
      lane_sel = '0;
      for (int i = 0; i < 8; i++) begin
         b[i] = 8'd0;
      end
      if (desc_ff.is_rx) begin
         b[0] = isotp_pkg::FC_CTS_BYTE;
         b[1] = isotp_pkg::FC_BS_BYTE;
         b[2] = isotp_pkg::FC_GAP_BYTE;
         used = 4'd3;
      end else begin
         used = hdr_n + desc_ff.cnt;
         for (int i = 0; i < 8; i++) begin
            lane_sel = desc_ff.rot + isotp_pkg::LANE_AW'(i - int'(hdr_n));
            if (i == 0) begin
               b[i] = desc_ff.hdr0;
            end else if (i == 1 && desc_ff.hdr_two) begin
               b[i] = desc_ff.hdr1;
            end else begin
               b[i] = lane_q[lane_sel];
            end
         end
      end
      tx_len = (cfg.pad_enable && used < 4'd8) ? 4'd8 : used;
      for (int i = 0; i < 8; i++) begin
         if (i < int'(used)) begin
            tx_data[8*i +: 8] = b[i];
         end else if (i < int'(tx_len)) begin
            tx_data[8*i +: 8] = cfg.pad_value;
         end else begin
            tx_data[8*i +: 8] = 8'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff      <= 1'b0;
         phase_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (load) begin
            held_ff  <= 1'b1;
            phase_ff <= 1'b0;
         end else if (emit && last_now) begin
            held_ff <= 1'b0;
         end else if (emit) begin
            phase_ff <= 1'b1;
         end
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         desc_ff <= desc_in;
      end
      if (emit) begin
         last_ff <= last_now;
         if (desc_ff.is_rx && !phase_ff) begin
            kind_ff <= 1'b1;
            id_ff   <= desc_ff.rx_id;
            ext_ff  <= desc_ff.rx_ext;
            len_ff  <= desc_ff.cnt;
            data_ff <= desc_ff.rx_data;
            off_ff  <= desc_ff.offset;
            mlen_ff <= desc_ff.mlen;
            done_ff <= desc_ff.done;
            gms_ff  <= 8'd0;
            gus_ff  <= 4'd0;
         end else begin
            kind_ff <= 1'b0;
            id_ff   <= cfg.tx_identifier;
            ext_ff  <= cfg.tx_extended;
            len_ff  <= tx_len;
            data_ff <= tx_data;
            off_ff  <= 12'd0;
            mlen_ff <= 12'd0;
            done_ff <= 1'b0;
            gms_ff  <= desc_ff.gms;
            gus_ff  <= desc_ff.gus;
         end
      end
   end

   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.kind             = kind_ff;
   assign rsp_chan.last             = last_ff;
   assign rsp_chan.frame_identifier = id_ff;
   assign rsp_chan.frame_extended   = ext_ff;
   assign rsp_chan.length_code      = len_ff;
   assign rsp_chan.data_bytes       = data_ff;
   assign rsp_chan.chunk_offset     = off_ff;
   assign rsp_chan.message_length   = mlen_ff;
   assign rsp_chan.message_done     = done_ff;
   assign rsp_chan.gap_ms           = gms_ff;
   assign rsp_chan.gap_hundred_us   = gus_ff;

endmodule

// ===== rtl/core/isotp_seg_checker.sv =====
module isotp_seg_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_kind,
   input logic [3:0]  rsp_length_code,
   input logic [11:0] rsp_chunk_offset,
   input logic [11:0] rsp_message_length,
   input logic        rsp_message_done,
   input logic [7:0]  rsp_gap_ms,
   input logic [3:0]  rsp_gap_hundred_us
);

   // A beat offered on the result side stays until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result beat dropped before it was taken");

   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   a_chunk_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind |-> rsp_gap_ms == 8'd0 && rsp_gap_hundred_us == 4'd0)
      else $error("received chunk carries a gap");

   a_frame_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_kind |->
         rsp_chunk_offset == 12'd0 && rsp_message_length == 12'd0 && !rsp_message_done)
      else $error("transmit frame carries chunk fields");

   a_chunk_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind |-> rsp_length_code <= 4'd7)
      else $error("received chunk longer than seven bytes");

endmodule

bind isotp_segment_reassemble isotp_seg_checker u_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_chan.valid),
   .rsp_ready          (rsp_chan.ready),
   .rsp_kind           (rsp_chan.kind),
   .rsp_length_code    (rsp_chan.length_code),
   .rsp_chunk_offset   (rsp_chan.chunk_offset),
   .rsp_message_length (rsp_chan.message_length),
   .rsp_message_done   (rsp_chan.message_done),
   .rsp_gap_ms         (rsp_chan.gap_ms),
   .rsp_gap_hundred_us (rsp_chan.gap_hundred_us)
);
